### rtl/core/bcq_pkg.sv
// ----------------------------------------------------------------------------
// bcq_pkg
// Shared types and constants of the beam candidate queue: request and
// result payloads, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package bcq_pkg;

    // Command codes of a request
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Register index of the beam size on the configuration port
    localparam logic REG_BEAM_SIZE = 1'b0;

    // Reset values
    localparam logic [4:0]         BEAM_SIZE_RESET = 5'd16;
    localparam logic signed [31:0] SCORE_MIN       = 32'sh8000_0000;

    // One request transfer
    typedef struct packed {
        logic                command;
        logic signed [31:0]  heuristic_score;
        logic [15:0]         node_index;
    } bcq_req_t;

    // One result transfer
    typedef struct packed {
        logic                accepted;
        logic                pop_valid;
        logic [15:0]         pop_index;
        logic signed [31:0]  pop_score;
        logic [4:0]          occupancy;
    } bcq_result_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load_worst;
    } bcq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic evict;
    } bcq_status_t;

endpackage

### rtl/core/bcq_ctrl.sv
// ----------------------------------------------------------------------------
// bcq_ctrl
// Controller of the beam candidate queue: sequences capture, execution and
// the worst-score reload, and raises the result strobe.
// ----------------------------------------------------------------------------
module bcq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bcq_pkg::bcq_status_t status,
    output bcq_pkg::bcq_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_WORST = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;

    // Next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = start ? ST_EXEC : ST_IDLE;
            ST_EXEC:  state_next = status.evict ? ST_WORST : ST_IDLE;
            ST_WORST: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Strobe the result once the item is complete
    assign done_next = ((state_reg == ST_EXEC) && !status.evict) || (state_reg == ST_WORST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Drive datapath commands
    assign cmd.capture    = start && (state_reg == ST_IDLE);
    assign cmd.exec       = (state_reg == ST_EXEC);
    assign cmd.load_worst = (state_reg == ST_WORST);

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### rtl/core/bcq_datapath.sv
// ----------------------------------------------------------------------------
// bcq_datapath
// Sorted shift chain of candidate cells, entry count, worst-score register
// and result register of the beam candidate queue.
// ----------------------------------------------------------------------------
module bcq_datapath #(
    parameter int BEAM_DEPTH = 16,
    parameter int INDEX_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bcq_pkg::bcq_cmd_t                cmd,
    input  bcq_pkg::bcq_req_t                request,
    input  logic [$clog2(BEAM_DEPTH+2)-1:0]  beam,
    output bcq_pkg::bcq_status_t             status,
    output bcq_pkg::bcq_result_t             result
);

    localparam int SLOTS = BEAM_DEPTH + 1;
    localparam int CW    = $clog2(BEAM_DEPTH + 2);
    localparam int NW    = (INDEX_BITS < 16) ? INDEX_BITS : 16;

    bcq_pkg::bcq_req_t    op_reg;
    bcq_pkg::bcq_result_t result_reg;
    bcq_pkg::bcq_result_t result_next;

    logic signed [31:0] score_reg  [SLOTS];
    logic signed [31:0] score_next [SLOTS];
    logic [NW-1:0]      node_reg   [SLOTS];
    logic [NW-1:0]      node_next  [SLOTS];
    logic signed [31:0] up_score   [SLOTS];
    logic [NW-1:0]      up_node    [SLOTS];
    logic signed [31:0] dn_score   [SLOTS];
    logic [NW-1:0]      dn_node    [SLOTS];

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] worst_reg;
    logic signed [31:0] worst_sel;

    logic [SLOTS-1:0]   ge;
    logic [SLOTS-1:0]   ge_prev;
    logic               is_insert;
    logic               full;
    logic               can_ins;
    logic               ins_en;
    logic               pop_en;
    logic [CW-1:0]      last_idx;

    // Capture the request on a start transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= request;
        end
    end

    // Per-cell compare: the entry stays ahead of the new candidate
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ge[i] = (CW'(i) < count_reg) && (score_reg[i] >= $signed(op_reg.heuristic_score));
        end
    end

    // Cell i takes the new entry when the cell before it stays put
    assign ge_prev = {ge[SLOTS-2:0], 1'b1};

    // Neighbor taps of the chain
    always_comb
    begin
        up_score[0] = $signed(op_reg.heuristic_score);
        up_node[0]  = op_reg.node_index[NW-1:0];
        for (int i = 1; i < SLOTS; i++)
        begin
            up_score[i] = score_reg[i-1];
            up_node[i]  = node_reg[i-1];
        end
        for (int i = 0; i < SLOTS - 1; i++)
        begin
            dn_score[i] = score_reg[i+1];
            dn_node[i]  = node_reg[i+1];
        end
        dn_score[SLOTS-1] = score_reg[SLOTS-1];
        dn_node[SLOTS-1]  = node_reg[SLOTS-1];
    end

    // Admission decision
    assign is_insert = (op_reg.command == bcq_pkg::CMD_INSERT);
    assign full      = (count_reg >= beam);
    assign can_ins   = !(full && ($signed(op_reg.heuristic_score) < worst_reg))
                       && (count_reg < CW'(SLOTS));
    assign ins_en    = cmd.exec && is_insert && can_ins;
    assign pop_en    = cmd.exec && !is_insert && (count_reg != '0);

    // An accepted insert into a full set drops the last entry
    assign status.evict = is_insert && can_ins && full;

    // Shift the chain: open a gap on insert, close the head on pop
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            score_next[i] = score_reg[i];
            node_next[i]  = node_reg[i];
            if (ins_en && !ge[i])
            begin
                if (ge_prev[i])
                begin
                    score_next[i] = up_score[0];
                    node_next[i]  = up_node[0];
                end
                else
                begin
                    score_next[i] = up_score[i];
                    node_next[i]  = up_node[i];
                end
            end
            else if (pop_en)
            begin
                score_next[i] = dn_score[i];
                node_next[i]  = dn_node[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            score_reg[i] <= score_next[i];
            node_reg[i]  <= node_next[i];
        end
    end

    // Count and result
    always_comb
    begin
        count_next  = count_reg;
        result_next = result_reg;
        if (cmd.exec)
        begin
            if (ins_en)
            begin
                count_next = full ? count_reg : count_reg + CW'(1);
            end
            else if (pop_en)
            begin
                count_next = count_reg - CW'(1);
            end
            result_next.accepted  = ins_en;
            result_next.pop_valid = pop_en;
            result_next.pop_index = pop_en ? 16'(node_reg[0]) : 16'd0;
            result_next.pop_score = pop_en ? score_reg[0] : 32'sd0;
            result_next.occupancy = 5'(count_next);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Select the new last entry after an eviction
    assign last_idx = count_reg - CW'(1);

    always_comb
    begin
        worst_sel = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            worst_sel = worst_sel | ((CW'(i) == last_idx) ? score_reg[i] : 32'sd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            worst_reg <= bcq_pkg::SCORE_MIN;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_worst)
            begin
                worst_reg <= worst_sel;
            end
        end
    end

    assign result = result_reg;

endmodule

### rtl/core/beam_candidate_queue.sv
// ----------------------------------------------------------------------------
// beam_candidate_queue
// Beam-limited sorted candidate set with insert and pop commands and an
// APB-style beam size register.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on result for exactly one cycle with done high, and must be taken then.
// An item passes the execute state before its done cycle, and a new start is
// taken in the done cycle; an evicting insert also passes the worst state,
// which reloads the worst-score register from the new last cell. Candidates
// sit in a chain of BEAM_DEPTH+1 cells that shifts one place per item, so
// the rate does not depend on the beam size. The beam size register must be
// written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module beam_candidate_queue #(
    parameter int BEAM_DEPTH = 16,
    parameter int INDEX_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bcq_pkg::bcq_req_t     request,
    output logic                  done,
    output bcq_pkg::bcq_result_t  result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW = $clog2(BEAM_DEPTH + 2);

    bcq_pkg::bcq_cmd_t    cmd;
    bcq_pkg::bcq_status_t status;

    logic [4:0]    beam_size_reg;
    logic [CW-1:0] beam;
    logic          reg_hit;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == bcq_pkg::REG_BEAM_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_size_reg <= bcq_pkg::BEAM_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            beam_size_reg <= pwdata[4:0];
        end
    end

    assign prdata = reg_hit ? 32'(beam_size_reg) : 32'd0;

    // Clamp the beam to the range the chain holds
    always_comb
    begin
        if (beam_size_reg == 5'd0)
        begin
            beam = CW'(1);
        end
        else if (32'(beam_size_reg) > 32'(BEAM_DEPTH))
        begin
            beam = CW'(BEAM_DEPTH);
        end
        else
        begin
            beam = CW'(beam_size_reg);
        end
    end

    bcq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    bcq_datapath #(
        .BEAM_DEPTH (BEAM_DEPTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .beam    (beam),
        .status  (status),
        .result  (result)
    );

endmodule
